// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: check failed");

// Antecedent true implies consequent sequence.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("%m: check failed");

`endif

// ===== sv/ulw_pkg.sv =====
// Shared types, constants and calendar functions for the UTC to local date block.
package ulw_pkg;

    localparam logic [13:0] YEAR_MIN   = 14'd1;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [3:0]  MONTH_JAN  = 4'd1;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;
    localparam logic [4:0]  DAY_FIRST  = 5'd1;
    localparam logic [4:0]  DAY_LAST   = 5'd31;
    localparam logic [4:0]  HOUR_MAX   = 5'd23;
    localparam logic [5:0]  HOURS_DAY  = 6'd24;
    localparam logic [4:0]  ZONE_OFFSET_RESET = 5'd8;

    // Register word index decoded from paddr[2]
    localparam logic REG_ZONE_OFFSET = 1'b0;

    // floor(y / 100) as (y * 5243) >> 19, exact for y below 43699
    localparam logic [12:0] DIV100_RECIP = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
    } date_t;

    // One pipeline stage: valid flag plus date payload
    typedef struct packed {
        logic  valid;
        date_t date;
    } stage_t;

    function automatic logic [6:0] div100(input logic [13:0] y);
        logic [26:0] prod;
        prod = 27'(y) * 27'(DIV100_RECIP);
        return prod[DIV100_SHIFT +: 7];
    endfunction

    // Gregorian leap rule
    function automatic logic is_leap(input logic [13:0] y);
        logic [6:0] q;
        logic       by100;
        q     = div100(y);
        by100 = ((14'(q) * 14'd100) == y);
        return ((y[1:0] == 2'b00) && !by100) || (by100 && (q[1:0] == 2'b00));
    endfunction

    // Month length, m in 1..12
    function automatic logic [4:0] days_in(input logic [13:0] y, input logic [3:0] m);
        logic [4:0] n;
        n = MONTH_LEN[4'(m - 4'd1)];
        if (m == MONTH_FEB && is_leap(y))
        begin
            n = 5'd29;
        end
        return n;
    endfunction

endpackage

// ===== sv/utc_to_local_date_weekday_top.sv =====
// Top level: UTC date/hour to local date, hour and weekday, with APB offset register.
//
//  Channel   | Signals                                       | Transfer
//  ----------+-----------------------------------------------+---------------------------
//  command   | start, busy, utc_year/month/day/hour          | start && !busy at clk edge
//  result    | done, local_year/month/day/hour, weekday      | done, one cycle, no stall
//  config    | psel, penable, pwrite, paddr, pwdata, prdata  | APB access, pready tied 1
//
// One transaction per cycle; each result passes through the input register, the date
// stage register and the weekday/output register in turn. busy is never asserted.
// Reset clears the valid pipeline and loads the zone offset with 8.
// The receiver cannot stall; each result strobe lasts one cycle.
module utc_to_local_date_weekday_top
    import ulw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [13:0] utc_year,
    input  logic [3:0]  utc_month,
    input  logic [4:0]  utc_day,
    input  logic [4:0]  utc_hour,
    output logic        done,
    output logic [13:0] local_year,
    output logic [3:0]  local_month,
    output logic [4:0]  local_day,
    output logic [4:0]  local_hour,
    output logic [2:0]  weekday,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       cfg_write;
    logic [4:0] zone_offset_reg;
    stage_t     in_stage_reg;
    stage_t     date_stage;
    stage_t     out_stage;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    // Configuration register
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_offset_reg <= ZONE_OFFSET_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_ZONE_OFFSET))
        begin
            zone_offset_reg <= pwdata[4:0];
        end
    end

    assign prdata = (paddr[2] == REG_ZONE_OFFSET) ? {27'd0, zone_offset_reg} : 32'd0;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_stage_reg <= '0;
        end
        else
        begin
            in_stage_reg.valid <= start && !busy;
            in_stage_reg.date  <= '{year: utc_year, month: utc_month, day: utc_day,
                                    hour: utc_hour};
        end
    end

    ulw_date u_date (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_stage    (in_stage_reg),
        .zone_offset (zone_offset_reg),
        .out_stage   (date_stage)
    );

    ulw_weekday u_weekday (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stage  (date_stage),
        .out_stage (out_stage),
        .weekday   (weekday)
    );

    assign done        = out_stage.valid;
    assign local_year  = out_stage.date.year;
    assign local_month = out_stage.date.month;
    assign local_day   = out_stage.date.day;
    assign local_hour  = out_stage.date.hour;

endmodule

// ===== sv/ulw_date.sv =====
// Date stage: input clamping, zone offset add and day/month/year rollover.
module ulw_date
    import ulw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_t     in_stage,
    input  logic [4:0] zone_offset,
    output stage_t     out_stage
);

    logic [4:0]  off;
    logic [4:0]  h;
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [4:0]  lim;
    logic [5:0]  hsum;
    logic        carry;
    date_t       date_next;
    stage_t      stage_reg;

    // Clamp fields into legal ranges
    always_comb
    begin
        off = (zone_offset > HOUR_MAX) ? HOUR_MAX : zone_offset;
        h   = (in_stage.date.hour > HOUR_MAX) ? HOUR_MAX : in_stage.date.hour;
        y   = in_stage.date.year;
        if (y < YEAR_MIN)
        begin
            y = YEAR_MIN;
        end
        else if (y > YEAR_MAX)
        begin
            y = YEAR_MAX;
        end
        m = in_stage.date.month;
        if (m < MONTH_JAN)
        begin
            m = MONTH_JAN;
        end
        else if (m > MONTH_DEC)
        begin
            m = MONTH_DEC;
        end
        lim = days_in(y, m);
        d   = in_stage.date.day;
        if (d < DAY_FIRST)
        begin
            d = DAY_FIRST;
        end
        else if (d > lim)
        begin
            d = lim;
        end
    end

    // Hour add and carry chain into day, month, year
    always_comb
    begin
        hsum  = {1'b0, h} + {1'b0, off};
        carry = (hsum >= HOURS_DAY);
        date_next.year  = y;
        date_next.month = m;
        date_next.day   = d;
        date_next.hour  = carry ? 5'(hsum - HOURS_DAY) : hsum[4:0];
        if (carry)
        begin
            if (d != lim)
            begin
                date_next.day = d + 5'd1;
            end
            else if (m != MONTH_DEC)
            begin
                date_next.day   = DAY_FIRST;
                date_next.month = m + 4'd1;
            end
            else if (y != YEAR_MAX)
            begin
                date_next.day   = DAY_FIRST;
                date_next.month = MONTH_JAN;
                date_next.year  = y + 14'd1;
            end
            else
            begin
                // last representable day: hold date
                date_next.day   = DAY_LAST;
                date_next.month = MONTH_DEC;
                date_next.year  = YEAR_MAX;
            end
        end
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg.valid <= in_stage.valid;
            stage_reg.date  <= date_next;
        end
    end

    assign out_stage = stage_reg;

endmodule

// ===== sv/ulw_weekday.sv =====
// Weekday stage: Zeller-style sum and mod-7 fold, registered with the date.
module ulw_weekday
    import ulw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_t     in_stage,
    output stage_t     out_stage,
    output logic [2:0] weekday
);

    // floor(3 * (m + 1) / 5) for m in 3..14
    function automatic logic [3:0] month_term(input logic [3:0] m);
        logic [3:0] t;
        case (m)
            4'd3:    t = 4'd2;
            4'd4:    t = 4'd3;
            4'd5:    t = 4'd3;
            4'd6:    t = 4'd4;
            4'd7:    t = 4'd4;
            4'd8:    t = 4'd5;
            4'd9:    t = 4'd6;
            4'd10:   t = 4'd6;
            4'd11:   t = 4'd7;
            4'd12:   t = 4'd7;
            4'd13:   t = 4'd8;
            4'd14:   t = 4'd9;
            default: t = 4'd0;
        endcase
        return t;
    endfunction

    logic        shift_year;
    logic [3:0]  mz;
    logic [13:0] yz;
    logic [6:0]  q;
    logic [14:0] zsum;
    logic [5:0]  fold1;
    logic [3:0]  fold2;
    logic [3:0]  fold3;
    logic [2:0]  wd0;
    stage_t      stage_reg;
    logic [2:0]  weekday_reg;

    // Jan/Feb count as months 13/14 of the previous year
    always_comb
    begin
        shift_year = (in_stage.date.month <= MONTH_FEB);
        mz = shift_year ? in_stage.date.month + 4'd12 : in_stage.date.month;
        yz = shift_year ? in_stage.date.year - 14'd1 : in_stage.date.year;
        q  = div100(yz);
    end

    // Sum, then fold mod 7 using 8 == 1 (mod 7); result 0 is Monday
    always_comb
    begin
        zsum = 15'(in_stage.date.day) + 15'({mz, 1'b0}) + 15'(month_term(mz))
             + 15'(yz) + 15'(yz >> 2) - 15'(q) + 15'(q >> 2);
        fold1 = 6'(zsum[2:0]) + 6'(zsum[5:3]) + 6'(zsum[8:6])
              + 6'(zsum[11:9]) + 6'(zsum[14:12]);
        fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
        fold3 = 4'(fold2[3]) + 4'(fold2[2:0]);
        wd0   = (fold3 >= 4'd7) ? 3'(fold3 - 4'd7) : fold3[2:0];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg   <= '0;
            weekday_reg <= '0;
        end
        else
        begin
            stage_reg.valid <= in_stage.valid;
            stage_reg.date  <= in_stage.date;
            weekday_reg     <= wd0 + 3'd1;
        end
    end

    assign out_stage = stage_reg;
    assign weekday   = weekday_reg;

endmodule

// ===== sv/ulw_checker.sv =====
// Port-level assertion checker for the UTC to local date block, with its bind.
`include "assert_macros.svh"

module ulw_checker
    import ulw_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [3:0]  local_month,
    input logic [4:0]  local_hour,
    input logic [2:0]  weekday
);

    // Every accepted transaction produces a result once through the input, date and weekday registers
    `ASSERT_IMPLIES(a_result_follows, clk, rst_n, start && !busy, ##3 done)

    // No result without an accepted transaction that has passed the input, date and weekday registers
    `ASSERT_IMPLIES(a_no_spurious, clk, rst_n, !(start && !busy), ##3 !done)

    // Result fields stay in calendar range
    `ASSERT_IMPLIES(a_result_range, clk, rst_n, done,
        (local_hour <= HOUR_MAX) && (weekday != 3'd0)
        && (local_month >= MONTH_JAN) && (local_month <= MONTH_DEC))

endmodule

bind utc_to_local_date_weekday_top ulw_checker u_ulw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .local_month (local_month),
    .local_hour  (local_hour),
    .weekday     (weekday)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the UTC to local date, hour and weekday block.
`timescale 1ns / 100ps

module testbench;
    import ulw_pkg::*;

    localparam int          RESET_CYCLES   = 11;
    localparam int          PIPE_LATENCY   = 3;
    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          HOURS_PER_DAY  = 24;
    localparam int          RANDOM_PER_SEG = 121;
    localparam logic [2:0]  ZONE_OFFSET_ADDR = {REG_ZONE_OFFSET, 2'b00};

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [2:0]  wday;
    } local_date_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [13:0] utc_year = '0;
    logic [3:0]  utc_month = '0;
    logic [4:0]  utc_day = '0;
    logic [4:0]  utc_hour = '0;
    logic        done;
    logic [13:0] local_year;
    logic [3:0]  local_month;
    logic [4:0]  local_day;
    logic [4:0]  local_hour;
    logic [2:0]  weekday;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the zone offset register, raw 5-bit value
    logic [4:0]  zone_offset_shadow = ZONE_OFFSET_RESET;
    local_date_t expected_dates[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          sender_idle_pct = 0;

    utc_to_local_date_weekday_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .utc_year    (utc_year),
        .utc_month   (utc_month),
        .utc_day     (utc_day),
        .utc_hour    (utc_hour),
        .done        (done),
        .local_year  (local_year),
        .local_month (local_month),
        .local_day   (local_day),
        .local_hour  (local_hour),
        .weekday     (weekday),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Gregorian leap rule
    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Days in month m (1..12) of year y
    function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return leap_year(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // 1 = Monday .. 7 = Sunday; Jan/Feb count as months 13/14 of the prior year
    function automatic int unsigned day_of_week(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
        int unsigned yy;
        int unsigned mm;
        yy = y;
        mm = m;
        if (mm <= 2)
        begin
            mm = mm + 12;
            yy = yy - 1;
        end
        return (d + 2 * mm + (3 * (mm + 1)) / 5 + yy + yy / 4 - yy / 100 + yy / 400) % 7 + 1;
    endfunction

    // Expected local date for one UTC transaction under a given raw offset
    function automatic local_date_t predict_local_date(input logic [13:0] yr_raw,
                                                       input logic [3:0]  mo_raw,
                                                       input logic [4:0]  dy_raw,
                                                       input logic [4:0]  hr_raw,
                                                       input logic [4:0]  offset_raw);
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned h;
        int unsigned off;
        int unsigned lim;
        int unsigned hsum;
        local_date_t res;
        y   = yr_raw;
        m   = mo_raw;
        d   = dy_raw;
        h   = hr_raw;
        off = offset_raw;
        // Out-of-range inputs are clamped first
        if (off > HOUR_MAX) off = HOUR_MAX;
        if (h > HOUR_MAX) h = HOUR_MAX;
        if (y < YEAR_MIN) y = YEAR_MIN;
        if (y > YEAR_MAX) y = YEAR_MAX;
        if (m < MONTH_JAN) m = MONTH_JAN;
        if (m > MONTH_DEC) m = MONTH_DEC;
        lim = month_days(y, m);
        if (d < DAY_FIRST) d = DAY_FIRST;
        if (d > lim) d = lim;
        // Hour carry into day, month, year; year saturates at the last day
        hsum = h + off;
        if (hsum >= HOURS_PER_DAY)
        begin
            hsum = hsum - HOURS_PER_DAY;
            d = d + 1;
            if (d > lim)
            begin
                d = DAY_FIRST;
                m = m + 1;
                if (m > MONTH_DEC)
                begin
                    m = MONTH_JAN;
                    y = y + 1;
                    if (y > YEAR_MAX)
                    begin
                        y = YEAR_MAX;
                        m = MONTH_DEC;
                        d = DAY_LAST;
                    end
                end
            end
        end
        res.year  = 14'(y);
        res.month = 4'(m);
        res.day   = 5'(d);
        res.hour  = 5'(hsum);
        res.wday  = 3'(day_of_week(y, m, d));
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Accepted transactions get a prediction; results are checked in order
    always @(posedge clk)
    begin
        local_date_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_dates.push_back(predict_local_date(utc_year, utc_month, utc_day,
                                                            utc_hour, zone_offset_shadow));
            end
            if (done)
            begin
                if (expected_dates.size() == 0)
                begin
                    report_mismatch("unexpected result, year", local_year, 0);
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (local_year !== want.year)
                        report_mismatch("local_year", local_year, want.year);
                    if (local_month !== want.month)
                        report_mismatch("local_month", local_month, want.month);
                    if (local_day !== want.day)
                        report_mismatch("local_day", local_day, want.day);
                    if (local_hour !== want.hour)
                        report_mismatch("local_hour", local_hour, want.hour);
                    if (weekday !== want.wday)
                        report_mismatch("weekday", weekday, want.wday);
                end
            end
        end
    end

    // Send one UTC transaction, with an optional random gap before it
    task automatic send_utc(input logic [13:0] yr, input logic [3:0] mo,
                            input logic [4:0] dy, input logic [4:0] hr);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start     <= 1'b1;
        utc_year  <= yr;
        utc_month <= mo;
        utc_day   <= dy;
        utc_hour  <= hr;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain_results;
        start <= 1'b0;
        @(posedge clk);
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic apb_write_offset(input logic [4:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ZONE_OFFSET_ADDR;
        pwdata  <= {27'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        zone_offset_shadow = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Read the offset register back and compare against the shadow
    task automatic apb_check_offset;
        logic [31:0] rdata;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ZONE_OFFSET_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (rdata !== {27'd0, zone_offset_shadow})
            report_mismatch("zone_offset_hours readback", rdata, zone_offset_shadow);
    endtask

    task automatic set_offset(input logic [4:0] value);
        drain_results();
        apb_write_offset(value);
        apb_check_offset();
    endtask

    // Reset offset of 8: leap rules, month/year rollover, saturation
    task automatic test_calendar_rollover;
        apb_check_offset();
        send_utc(14'd2000, 4'd2, 5'd28, 5'd20);   // century leap year
        send_utc(14'd1900, 4'd2, 5'd28, 5'd20);   // century non-leap
        send_utc(14'd2024, 4'd12, 5'd31, 5'd23);  // new year
        send_utc(14'd9999, 4'd12, 5'd31, 5'd16);  // saturates at the last day
        send_utc(14'd9999, 4'd12, 5'd31, 5'd10);  // no carry near the top
        send_utc(14'd1, 4'd1, 5'd1, 5'd0);
        send_utc(14'd2023, 4'd6, 5'd15, 5'd15);
    endtask

    // Out-of-range field values are clamped
    task automatic test_input_clamps;
        send_utc(14'd0, 4'd3, 5'd10, 5'd5);
        send_utc(14'h3FFF, 4'd7, 5'd4, 5'd12);
        send_utc(14'd2021, 4'd0, 5'd5, 5'd3);
        send_utc(14'd2021, 4'hF, 5'd31, 5'd20);
        send_utc(14'd2022, 4'd5, 5'd0, 5'd1);
        send_utc(14'd2022, 4'd4, 5'd31, 5'd22);
        send_utc(14'd2023, 4'd2, 5'd30, 5'd9);
        send_utc(14'd2022, 4'd8, 5'd8, 5'h1F);
    endtask

    // Offset extremes, including values above 23
    task automatic test_offset_extremes;
        set_offset(5'd0);
        send_utc(14'd2022, 4'd12, 5'd31, 5'd23);
        set_offset(5'd23);
        send_utc(14'd2022, 4'd12, 5'd31, 5'd1);
        send_utc(14'd2022, 4'd1, 5'd1, 5'd23);
        set_offset(5'h1F);
        send_utc(14'd2020, 4'd2, 5'd28, 5'd1);
        send_utc(14'd9999, 4'd12, 5'd31, 5'd23);
        set_offset(5'd24);
        send_utc(14'd2100, 4'd2, 5'd28, 5'd0);
    endtask

    // Mostly well-formed dates biased toward month ends; some raw noise
    task automatic send_random_utc;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned lim;
        if ($urandom_range(99) < 20)
        begin
            send_utc(14'($urandom), 4'($urandom), 5'($urandom), 5'($urandom));
        end
        else
        begin
            case ($urandom_range(19))
                0:       y = YEAR_MAX;
                1, 2, 3: y = 100 * $urandom_range(1, 99);
                default: y = $urandom_range(1, 9999);
            endcase
            m = $urandom_range(1, 12);
            if ($urandom_range(99) < 10)
                m = MONTH_DEC;
            lim = month_days(y, m);
            case ($urandom_range(3))
                0:       d = lim;
                1:       d = lim - $urandom_range(0, 1);
                default: d = $urandom_range(1, lim);
            endcase
            send_utc(14'(y), 4'(m), 5'(d), 5'($urandom_range(0, 23)));
        end
    endtask

    // Three idle phases, each split across several offset settings
    task automatic test_random_dates;
        int idle_pct[3] = '{34, 81, 0};
        logic [4:0] seg_offset;
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = idle_pct[phase];
            for (int seg = 0; seg < 4; seg++)
            begin
                case (seg)
                    0:       seg_offset = 5'd0;
                    1:       seg_offset = 5'd23;
                    2:       seg_offset = 5'($urandom_range(24, 31));
                    default: seg_offset = 5'($urandom_range(0, 23));
                endcase
                set_offset(seg_offset);
                for (int n = 0; n < RANDOM_PER_SEG; n++)
                    send_random_utc();
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_calendar_rollover();
        test_input_clamps();
        test_offset_extremes();
        test_random_dates();
        drain_results();
        repeat (4 * PIPE_LATENCY) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
